### design/tili_pkg.sv
// ----------------------------------------------------------------------------
// tili_pkg
// Shared types and constants for the calibration table lookup with inverse
// linear interpolation.
// ----------------------------------------------------------------------------
package tili_pkg;

  localparam int DATA_W  = 24;
  localparam int LEN_W   = 9;
  localparam int IDX_W   = 8;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int PROD_W  = 2 * DATA_W;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic REG_TABLE_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 9'd2;
  localparam logic [DATA_W-1:0] DEFAULT_T1 = 24'h500000;

  typedef logic signed [DATA_W-1:0] intensity_t;
  typedef logic        [DATA_W-1:0] t1_t;

endpackage

### design/table_inverse_linear_interp.sv
// ----------------------------------------------------------------------------
// table_inverse_linear_interp
// Maps a signed Q4.20 intensity to an unsigned Q4.20 T1 value through a
// loaded calibration table, by inverse linear interpolation.
// ----------------------------------------------------------------------------
// A load transfer (cmd = 0) writes one (intensity, T1) pair and gives no
// result; indexes at or above TABLE_DEPTH are dropped. A convert transfer
// (cmd = 1) scans the table one entry per cycle through the registered read
// port of the table memories, taking the first interval where intensity[j] >
// sample > intensity[j+1]. The weighted sum is formed on one shared 24x24
// multiplier in two passes and divided by a restoring divider that resolves
// one quotient bit per cycle. A convert runs through the scan, the multiply
// and sum steps, the divide and a result step; when no interval
// matches the result is 5.0 with found low. in_ready is low while a convert
// is in progress. The table holds no reset value: every entry up to
// table_length - 1 must be loaded before a convert.
// ----------------------------------------------------------------------------
module table_inverse_linear_interp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [tili_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [tili_pkg::DATA_W-1:0] in_table_intensity,
  input  logic [tili_pkg::DATA_W-1:0]   in_table_t1,
  input  logic signed [tili_pkg::DATA_W-1:0] in_sample,
  input  logic                          in_block_last,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tili_pkg::DATA_W-1:0]   out_t1_value,
  output logic                          out_found,
  output logic                          out_block_last_res,

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tili_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [tili_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [tili_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import tili_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = AW + 1;
  localparam int CW  = (SW > LEN_W) ? SW : LEN_W;
  localparam int EW  = (SW > IDX_W) ? SW : IDX_W;
  localparam int DIV_STEPS = DATA_W;
  localparam int DCW = $clog2(DIV_STEPS);

  localparam logic [CW-1:0] DEPTH_LEN = CW'(TABLE_DEPTH);
  localparam logic [EW-1:0] DEPTH_IDX = EW'(TABLE_DEPTH);
  localparam logic [SW-1:0] SCAN_TWO  = SW'(2);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL_HI,
    S_MUL_LO,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [LEN_W-1:0]    len_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_t1_r;
  logic                out_found_r;
  logic                out_last_r;

  intensity_t          sample_r;
  logic                last_r;
  logic [SW-1:0]       scan_idx_r;
  intensity_t          prev_int_r;
  t1_t                 prev_t1_r;
  logic [DATA_W-1:0]   a_r;
  logic [DATA_W-1:0]   b_r;
  logic [DATA_W-1:0]   d_r;
  t1_t                 t1_hi_r;
  t1_t                 t1_lo_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   acc_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   quo_r;
  logic [DCW-1:0]      div_cnt_r;
  t1_t                 res_r;
  logic                found_r;

  intensity_t          int_mem [TABLE_DEPTH];
  t1_t                 t1_mem  [TABLE_DEPTH];
  intensity_t          int_rd_r;
  t1_t                 t1_rd_r;

  logic                cfg_wr;
  logic [CW-1:0]       len_ext;
  logic [SW-1:0]       len_eff;
  logic [EW-1:0]       idx_ext;
  logic                load_wr;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                bracket;
  logic [DATA_W:0]     a_full;
  logic [DATA_W:0]     b_full;
  logic [DATA_W:0]     d_full;
  logic [DATA_W-1:0]   mul_x;
  logic [DATA_W-1:0]   mul_y;
  logic [PROD_W-1:0]   mul_out;
  logic [PROD_W:0]     sum;
  logic [DATA_W:0]     div_trial;
  logic [DATA_W+1:0]   div_diff;
  logic                div_ge;
  logic [DATA_W-1:0]   rem_step;
  logic [DATA_W-1:0]   quo_step;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_TABLE_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_TABLE_LENGTH)
                      ? APB_DW'(len_r) : '0;

  assign len_ext = CW'(len_r);
  assign len_eff = (len_ext > DEPTH_LEN) ? SW'(TABLE_DEPTH) : len_ext[SW-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign idx_ext  = EW'(in_entry_index);
  assign load_wr  = in_valid && in_ready && (in_cmd == CMD_LOAD) && (idx_ext < DEPTH_IDX);
  assign wr_addr  = idx_ext[AW-1:0];
  assign rd_addr  = scan_idx_r[AW-1:0];

  assign bracket = (sample_r < prev_int_r) && (sample_r > int_rd_r);
  assign a_full  = {sample_r[DATA_W-1], sample_r} - {int_rd_r[DATA_W-1], int_rd_r};
  assign b_full  = {prev_int_r[DATA_W-1], prev_int_r} - {sample_r[DATA_W-1], sample_r};
  assign d_full  = {prev_int_r[DATA_W-1], prev_int_r} - {int_rd_r[DATA_W-1], int_rd_r};

  assign mul_x   = (state_r == S_MUL_HI) ? t1_hi_r : t1_lo_r;
  assign mul_y   = (state_r == S_MUL_HI) ? a_r : b_r;
  assign mul_out = mul_x * mul_y;
  assign sum     = {1'b0, acc_r} + {1'b0, prod_r};

  assign div_trial = {rem_r, quo_r[DATA_W-1]};
  assign div_diff  = {1'b0, div_trial} - {2'b00, d_r};
  assign div_ge    = !div_diff[DATA_W+1];
  assign rem_step  = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
  assign quo_step  = {quo_r[DATA_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (load_wr) begin
      int_mem[wr_addr] <= in_table_intensity;
      t1_mem[wr_addr]  <= in_table_t1;
    end
    int_rd_r <= int_mem[rd_addr];
    t1_rd_r  <= t1_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= LEN_RESET;
    end else begin
      if (cfg_wr) begin
        len_r <= cfg_pwdata[LEN_W-1:0];
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          scan_idx_r <= '0;
          if (in_valid && (in_cmd == CMD_CONVERT)) begin
            sample_r <= in_sample;
            last_r   <= in_block_last;
            if (len_eff < SCAN_TWO) begin
              res_r   <= DEFAULT_T1;
              found_r <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          prev_int_r <= int_rd_r;
          prev_t1_r  <= t1_rd_r;
          if ((scan_idx_r >= SCAN_TWO) && bracket) begin
            a_r     <= a_full[DATA_W-1:0];
            b_r     <= b_full[DATA_W-1:0];
            d_r     <= d_full[DATA_W-1:0];
            t1_hi_r <= prev_t1_r;
            t1_lo_r <= t1_rd_r;
            state_r <= S_MUL_HI;
          end else if (scan_idx_r == len_eff) begin
            res_r   <= DEFAULT_T1;
            found_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            scan_idx_r <= scan_idx_r + SW'(1);
          end
        end
        S_MUL_HI: begin
          prod_r  <= mul_out;
          state_r <= S_MUL_LO;
        end
        S_MUL_LO: begin
          acc_r   <= prod_r;
          prod_r  <= mul_out;
          state_r <= S_SUM;
        end
        S_SUM: begin
          rem_r     <= sum[PROD_W-1:DATA_W];
          quo_r     <= sum[DATA_W-1:0];
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= rem_step;
          quo_r     <= quo_step;
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DIV_LAST) begin
            res_r   <= quo_step;
            found_r <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_t1_r    <= res_r;
            out_found_r <= found_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_t1_value       = out_t1_r;
  assign out_found          = out_found_r;
  assign out_block_last_res = out_last_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= len_eff))
    else $error("scan index past table length");

  a_interval_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_HI) |->
      (a_r != '0) && (b_r != '0) && ({1'b0, d_r} == ({1'b0, a_r} + {1'b0, b_r})))
    else $error("interval weights do not add up to divisor");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_ready |=> (state_r == S_DONE))
    else $error("result left done state while output stalled");

endmodule

### tb/sv/table_inverse_linear_interp_tb.sv
// ----------------------------------------------------------------------------
// table_inverse_linear_interp_tb
// Self-checking testbench for the calibration table lookup. Loads tables of
// many shapes (descending, stepped with duplicates, ascending, noise), sweeps
// table_length over its extremes through the APB port, and converts samples
// inside, on and outside the table intervals. A scoreboard predicts every
// result from the transfers accepted on the input channel and checks the
// result channel in order, under random idling on both sides for the first two thirds of the items.
// ----------------------------------------------------------------------------
module table_inverse_linear_interp_tb;
  import tili_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUT_DEPTH     = 256;
  localparam int INTENSITY_MAX = 8388607;
  localparam int INTENSITY_MIN = -8388608;
  localparam int ITEM_TARGET   = 1800;

  typedef struct {
    logic        cmd;
    logic [IDX_W-1:0] idx;
    intensity_t  inten;
    t1_t         t1;
    intensity_t  sample;
    logic        last;
  } lookup_item_t;

  typedef struct {
    t1_t  t1_value;
    logic found;
    logic block_last_res;
  } t1_result_t;

  class t1_scoreboard;
    intensity_t       inten_tab [LUT_DEPTH];
    t1_t              t1_tab    [LUT_DEPTH];
    logic [LEN_W-1:0] table_len;
    t1_result_t       expected_t1 [$];
    int               errors;

    function new();
      table_len = LEN_RESET;
      errors    = 0;
      foreach (inten_tab[k]) begin
        inten_tab[k] = '0;
        t1_tab[k]    = '0;
      end
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
      table_len = len;
    endfunction

    function int pending();
      return expected_t1.size();
    endfunction

    function void note_transfer(lookup_item_t it);
      t1_result_t  r;
      int          n;
      longint      s, hi, lo;
      logic [63:0] a, b, num, q;
      if (it.cmd == CMD_LOAD) begin
        if (int'(it.idx) < LUT_DEPTH) begin
          inten_tab[it.idx] = it.inten;
          t1_tab[it.idx]    = it.t1;
        end
        return;
      end
      n = (int'(table_len) > LUT_DEPTH) ? LUT_DEPTH : int'(table_len);
      r.t1_value       = DEFAULT_T1;
      r.found          = 1'b0;
      r.block_last_res = it.last;
      s = longint'(it.sample);
      for (int j = 0; j + 1 < n; j++) begin
        hi = longint'(inten_tab[j]);
        lo = longint'(inten_tab[j+1]);
        if (s < hi && s > lo) begin
          a   = s - lo;
          b   = hi - s;
          num = 64'(t1_tab[j]) * a + 64'(t1_tab[j+1]) * b;
          q   = num / (a + b);
          if (q > 64'hFFFFFF) q = 64'hFFFFFF;
          r.t1_value = q[DATA_W-1:0];
          r.found    = 1'b1;
          break;
        end
      end
      expected_t1.push_back(r);
    endfunction

    function void check_result(t1_t got_t1, logic got_found, logic got_last);
      t1_result_t e;
      if (expected_t1.size() == 0) begin
        $error("result with nothing expected: t1_value %h found %b block_last_res %b",
               got_t1, got_found, got_last);
        errors++;
        return;
      end
      e = expected_t1.pop_front();
      if (got_t1 !== e.t1_value) begin
        $error("t1_value: expected %h, got %h", e.t1_value, got_t1);
        errors++;
      end
      if (got_found !== e.found) begin
        $error("found: expected %b, got %b", e.found, got_found);
        errors++;
      end
      if (got_last !== e.block_last_res) begin
        $error("block_last_res: expected %b, got %b", e.block_last_res, got_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic             in_valid;
  logic             in_ready;
  logic             in_cmd;
  logic [IDX_W-1:0] in_entry_index;
  intensity_t       in_table_intensity;
  t1_t              in_table_t1;
  intensity_t       in_sample;
  logic             in_block_last;

  logic             out_valid;
  logic             out_ready;
  t1_t              out_t1_value;
  logic             out_found;
  logic             out_block_last_res;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  t1_scoreboard sb = new();
  int items_sent    = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 74;
  int cfg_errors    = 0;

  table_inverse_linear_interp #(.TABLE_DEPTH(LUT_DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_table_intensity (in_table_intensity),
    .in_table_t1        (in_table_t1),
    .in_sample          (in_sample),
    .in_block_last      (in_block_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_t1_value       (out_t1_value),
    .out_found          (out_found),
    .out_block_last_res (out_block_last_res),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_t1_value, out_found, out_block_last_res);
    end
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic send_item(input lookup_item_t it);
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 19;
      recv_idle_pct = 74;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 74;
      recv_idle_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= it.cmd;
    in_entry_index     <= it.idx;
    in_table_intensity <= it.inten;
    in_table_t1        <= it.t1;
    in_sample          <= it.sample;
    in_block_last      <= it.last;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(it);
    items_sent++;
  endtask

  task automatic send_load(input int idx, input int inten, input t1_t t1);
    lookup_item_t it;
    it.cmd    = CMD_LOAD;
    it.idx    = idx[IDX_W-1:0];
    it.inten  = intensity_t'(inten);
    it.t1     = t1;
    it.sample = intensity_t'($urandom);
    it.last   = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_convert(input int sample, input logic last);
    lookup_item_t it;
    it.cmd    = CMD_CONVERT;
    it.idx    = IDX_W'($urandom);
    it.inten  = intensity_t'($urandom);
    it.t1     = t1_t'($urandom);
    it.sample = intensity_t'(sample);
    it.last   = last;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_table_length(input logic [APB_DW-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TABLE_LENGTH, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_length(value[LEN_W-1:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[LEN_W-1:0] !== value[LEN_W-1:0]) begin
      $error("table_length: expected %0d, got %0d", value[LEN_W-1:0],
             cfg_prdata[LEN_W-1:0]);
      cfg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic t1_t random_t1();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return t1_t'($urandom_range(255, 0));
      default: return t1_t'($urandom);
    endcase
  endfunction

  function automatic int random_intensity();
    return int'(intensity_t'($urandom));
  endfunction

  task automatic run_directed();
    write_table_length(32'd0);
    send_convert(0, 1'b1);
    send_convert(INTENSITY_MAX, 1'b0);
    write_table_length(32'd1);
    send_convert(INTENSITY_MIN, 1'b1);
    write_table_length(32'hFFFF_FE02);
    send_load(0, INTENSITY_MAX, 24'h000000);
    send_load(1, INTENSITY_MIN, 24'hFFFFFF);
    send_convert(0, 1'b0);
    send_convert(INTENSITY_MAX, 1'b0);
    send_convert(INTENSITY_MIN, 1'b1);
    send_convert(INTENSITY_MAX - 1, 1'b0);
    send_convert(INTENSITY_MIN + 1, 1'b1);
    send_convert(-1, 1'b0);
    send_load(255, INTENSITY_MIN, 24'hFFFFFF);
    send_convert(1, 1'b1);
    send_load(0, INTENSITY_MAX, 24'hFFFFFF);
    send_convert(12345, 1'b0);
    send_load(1, INTENSITY_MIN, 24'h000000);
    send_load(0, INTENSITY_MAX, 24'h000000);
    send_convert(-12345, 1'b1);
    send_load(0, 100, 24'h500000);
    send_load(1, 98, 24'h100000);
    send_convert(99, 1'b0);
  endtask

  task automatic run_phase(input int phase);
    int len, n, style, n_conv, j, k, v, mode, s, p, lo, hi;
    int vals [$];
    int order [$];
    logic [APB_DW-1:0] wdata;
    if (phase == 4) len = 256;
    else if (phase == 15) len = 511;
    else if (phase == 30) len = $urandom_range(510, 257);
    else begin
      p = $urandom_range(99, 0);
      if (p < 3) len = 0;
      else if (p < 6) len = 1;
      else if (p < 80) len = $urandom_range(12, 2);
      else len = $urandom_range(40, 13);
    end
    wdata = $urandom;
    wdata[LEN_W-1:0] = len[LEN_W-1:0];
    write_table_length(wdata);
    n = (len > LUT_DEPTH) ? LUT_DEPTH : len;

    for (k = 0; k < n; k++) vals.push_back(random_intensity());
    style = $urandom_range(9, 0);
    if (style <= 3) begin
      vals.rsort();
      for (k = 1; k < n; k++) if ($urandom_range(15, 0) == 0) vals[k] = vals[k-1];
    end else if (style <= 5) begin
      v = int'($urandom_range(8388607, 0)) - 4194304;
      for (k = 0; k < n; k++) begin
        vals[k] = v;
        v -= int'($urandom_range(3, 0));
      end
    end else if (style == 6 && n > 0) begin
      vals.rsort();
      vals[0]   = INTENSITY_MAX;
      vals[n-1] = INTENSITY_MIN;
    end else if (style == 7) begin
      vals.sort();
    end

    for (k = 0; k < n; k++) order.push_back(k);
    if ($urandom_range(1, 0)) order.shuffle();
    foreach (order[q]) send_load(order[q], vals[order[q]], random_t1());
    if (n < LUT_DEPTH && $urandom_range(3, 0) == 0) begin
      send_load($urandom_range(LUT_DEPTH - 1, n), random_intensity(), random_t1());
    end

    if ($urandom_range(3, 0) == 0) wait_drained();
    n_conv = (n > 64) ? $urandom_range(8, 4) : $urandom_range(30, 10);
    repeat (n_conv) begin
      if (n >= 1 && $urandom_range(9, 0) == 0) begin
        k = $urandom_range(n - 1, 0);
        vals[k] = random_intensity();
        send_load(k, vals[k], random_t1());
      end
      mode = $urandom_range(9, 0);
      if (n >= 2) begin
        j  = $urandom_range(n - 2, 0);
        hi = vals[j];
        lo = vals[j+1];
      end
      if (n >= 2 && mode < 5 && hi - lo >= 2) s = lo + 1 + int'($urandom_range(hi - lo - 2, 0));
      else if (n >= 1 && mode < 7) s = vals[$urandom_range(n - 1, 0)];
      else if (n >= 2 && mode == 7) s = hi + ($urandom_range(1, 0) ? 1 : -1);
      else if (mode == 8) s = $urandom_range(1, 0) ? INTENSITY_MAX : INTENSITY_MIN;
      else s = random_intensity();
      send_convert(s, ($urandom_range(7, 0) == 0));
    end
  endtask

  initial begin
    int phase;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_cmd             <= CMD_LOAD;
    in_entry_index     <= '0;
    in_table_intensity <= '0;
    in_table_t1        <= '0;
    in_sample          <= '0;
    in_block_last      <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(64'd50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
